// ===== rtl/kruskal_union_find_mst_weight_unit_defines.svh =====
// Assertion macros for the spanning-forest weight unit.
// Included by the top level; depends on nothing else.
`ifndef KRUSKAL_UNION_FIND_MST_WEIGHT_UNIT_DEFINES_SVH
`define KRUSKAL_UNION_FIND_MST_WEIGHT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KUFM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KUFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kufm_pkg.sv =====
// Shared widths, constants and controller/datapath structs for the
// spanning-forest weight unit. Depends on nothing.
`default_nettype none

package kufm_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VERT_BITS    = 10;
  localparam int COUNT_BITS   = 11;
  localparam int WEIGHT_BITS  = 16;
  localparam int SUM_BITS     = 26;
  localparam int RANK_BITS    = 4;

  typedef logic [VERT_BITS-1:0]   vertex_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [RANK_BITS-1:0]   rank_t;

  localparam count_t  VC_RESET  = COUNT_BITS'(MAX_VERTICES);
  localparam count_t  VC_LIMIT  = COUNT_BITS'(MAX_VERTICES);
  localparam vertex_t LAST_VERT = VERT_BITS'(MAX_VERTICES - 1);
  localparam rank_t   RANK_MAX  = '1;
  localparam sum_t    SUM_MAX   = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input beat and its flags
    logic start_walk;  // cur <= selected endpoint, read its parent
    logic find_step;   // climb one level towards the root
    logic save_root;   // current vertex is the root of the selected side
    logic comp_step;   // point cur at the root and move to its old parent
    logic sel_b;       // selects the second endpoint / root
    logic rank_b;      // rank read address: root b instead of root a
    logic rank_cap;    // capture the rank of root a
    logic link;        // merge the two sets and add the weight
    logic publish;     // load the result register
    logic clear_sums;  // clear running sum and previous weight
    logic clear_step;  // reset one table entry of the clearing pass
  } kufm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // parent of cur is cur itself
    logic at_root_a;   // cur equals root a
    logic at_root_b;   // cur equals root b
    logic same_root;   // both endpoints lie in one set
    logic bad;         // an endpoint is out of range
    logic last;        // the item closes the run
    logic clr_last;    // clearing pass is at its final entry
    logic out_free;    // result register can take a new result
  } kufm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/kufm_if.sv =====
// Handshake channels of the spanning-forest weight unit: edge input,
// result output and vertex count write. Depends on kufm_pkg.
`default_nettype none

interface kufm_edge_if import kufm_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t edge_from;
  vertex_t edge_to;
  weight_t edge_weight;
  logic    last_edge;

  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface kufm_result_if import kufm_pkg::*; ();
  logic valid;
  logic ready;
  logic edge_joined;
  sum_t run_total;
  logic bad_vertex;
  logic out_of_order;
  logic run_done;

  modport source (output valid, edge_joined, run_total, bad_vertex, out_of_order,
                  run_done, input ready);
  modport sink (input valid, edge_joined, run_total, bad_vertex, out_of_order,
                run_done, output ready);
endinterface

interface kufm_cfg_if import kufm_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t vert_count;

  modport source (output valid, vert_count, input ready);
  modport sink (input valid, vert_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/kruskal_union_find_mst_weight_unit.sv =====
// Kruskal spanning-forest weight unit over a union-find forest.
// Out-of-range edges go straight to the result; otherwise each endpoint is found and
// its path compressed in turn, then the two roots are linked unless they share a set.
// The walks share the single read port of the parent memory; depths are at most 10.
// Throughput: one edge at a time; the next is taken the cycle after the result loads, unless that edge closed the run.
// Reset, and the result of the last edge, start a clearing pass over all 1024 entries
// of the parent and rank memories during which no edge is accepted.
`default_nettype none

`include "kruskal_union_find_mst_weight_unit_defines.svh"

module kruskal_union_find_mst_weight_unit import kufm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  kufm_cfg_if.sink             cfg,
  kufm_edge_if.sink            edges,
  kufm_result_if.source        results
);

  kufm_cmd_t  cmd;
  kufm_stat_t stat;

  // Terms watched by the checks below.
  logic [2:0] mem_writers;
  logic       edge_beat;
  logic       bad_joined;

  // The vertex count register takes a write beat in any cycle.
  assign cfg.ready = 1'b1;

  // Sequencer.
  kufm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edges.valid),
    .in_ready (edges.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Forest storage and arithmetic.
  kufm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.vert_count),
    .in_from    (edges.edge_from),
    .in_to      (edges.edge_to),
    .in_weight  (edges.edge_weight),
    .in_last    (edges.last_edge),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_joined (results.edge_joined),
    .out_total  (results.run_total),
    .out_bad    (results.bad_vertex),
    .out_late   (results.out_of_order),
    .out_last   (results.run_done)
  );

  assign mem_writers = {cmd.comp_step, cmd.link, cmd.clear_step};
  assign edge_beat   = edges.valid && edges.ready;
  assign bad_joined  = results.edge_joined && results.bad_vertex;

  // Only one source may drive the memory write ports in a cycle.
  `KUFM_ASSERT_NOW(a_one_writer, clk, rst, 1'b1, $onehot0(mem_writers), "two memory writers")
  // An accepted edge keeps the input closed until its work is done.
  `KUFM_ASSERT_NEXT(a_one_item, clk, rst, edge_beat, !edges.ready, "input reopened at once")
  // An ignored edge never joins two sets.
  `KUFM_ASSERT_NOW(a_bad_not_joined, clk, rst, results.valid, !bad_joined, "bad edge joined")

endmodule

`default_nettype wire

// ===== rtl/kufm_datapath.sv =====
// Datapath: parent and rank memories, walk pointer, roots, running sum,
// vertex count register and result register. Depends on kufm_pkg.
`default_nettype none

module kufm_datapath import kufm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  kufm_cmd_t  cmd,
  output kufm_stat_t stat,
  input  logic       cfg_we,
  input  count_t     cfg_data,
  input  vertex_t    in_from,
  input  vertex_t    in_to,
  input  weight_t    in_weight,
  input  logic       in_last,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_joined,
  output sum_t       out_total,
  output logic       out_bad,
  output logic       out_late,
  output logic       out_last
);

  // Disjoint-set forest storage.
  vertex_t parent_mem [MAX_VERTICES];
  rank_t   rank_mem   [MAX_VERTICES];

  count_t  vert_count;
  sum_t    sum;
  weight_t prev_w;
  vertex_t clr_cnt;

  vertex_t e_from;
  vertex_t e_to;
  weight_t e_weight;
  logic    e_last;
  logic    bad;
  logic    late;
  logic    joined;
  vertex_t cur;
  vertex_t root_a;
  vertex_t root_b;
  rank_t   rank_a;

  vertex_t p_rdata;
  vertex_t p_raddr;
  vertex_t p_waddr;
  vertex_t p_wdata;
  logic    p_we;
  rank_t   r_rdata;
  vertex_t r_raddr;
  vertex_t r_waddr;
  rank_t   r_wdata;
  logic    r_we;

  vertex_t v_sel;
  vertex_t root_sel;
  count_t  limit;
  logic    in_bad;
  logic [SUM_BITS:0] sum_ext;
  sum_t    sum_sat;

  // Endpoint and root selection, range check and saturating sum.
  always_comb begin
    v_sel    = cmd.sel_b ? e_to : e_from;
    root_sel = cmd.sel_b ? root_b : root_a;
    limit    = (vert_count > VC_LIMIT) ? VC_LIMIT : vert_count;
    in_bad   = ({1'b0, in_from} >= limit) || ({1'b0, in_to} >= limit);
    sum_ext  = {1'b0, sum} + (SUM_BITS + 1)'(e_weight);
    sum_sat  = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
    p_raddr  = cmd.start_walk ? v_sel : p_rdata;
    r_raddr  = cmd.rank_b ? root_b : root_a;
  end

  // Write port selection: clearing pass, path compression or link.
  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = root_sel;
    r_we    = 1'b0;
    r_waddr = root_a;
    r_wdata = rank_a + 1'b1;
    if (cmd.clear_step) begin
      p_we    = 1'b1;
      p_waddr = clr_cnt;
      p_wdata = clr_cnt;
      r_we    = 1'b1;
      r_waddr = clr_cnt;
      r_wdata = '0;
    end else if (cmd.comp_step) begin
      p_we = 1'b1;
    end else if (cmd.link) begin
      p_we = 1'b1;
      if (rank_a < r_rdata) begin
        p_waddr = root_a;
        p_wdata = root_b;
      end else begin
        p_waddr = root_b;
        p_wdata = root_a;
        r_we    = (rank_a == r_rdata) && (rank_a != RANK_MAX);
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.hit       = (p_rdata == cur);
    stat.at_root_a = (cur == root_a);
    stat.at_root_b = (cur == root_b);
    stat.same_root = (root_a == root_b);
    stat.bad       = bad;
    stat.last      = e_last;
    stat.clr_last  = (clr_cnt == LAST_VERT);
    stat.out_free  = !out_valid || out_ready;
  end

  // Memories: one write and one registered read a cycle each.
  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rdata <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    r_rdata <= rank_mem[r_raddr];
  end

  // Control state: configuration, running sums, sweep counter, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_count <= VC_RESET;
      sum        <= '0;
      prev_w     <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        vert_count <= cfg_data;
      end
      if (cmd.load) begin
        prev_w <= in_weight;
      end
      if (cmd.link) begin
        sum <= sum_sat;
      end
      if (cmd.clear_sums) begin
        sum    <= '0;
        prev_w <= '0;
      end
      if (cmd.clear_step) begin
        clr_cnt <= stat.clr_last ? '0 : clr_cnt + 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload, walk pointer, roots and result beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_from   <= in_from;
      e_to     <= in_to;
      e_weight <= in_weight;
      e_last   <= in_last;
      bad      <= in_bad;
      late     <= (in_weight < prev_w);
      joined   <= 1'b0;
    end
    if (cmd.start_walk) begin
      cur <= v_sel;
    end else if (cmd.find_step || cmd.comp_step) begin
      cur <= p_rdata;
    end
    if (cmd.save_root) begin
      if (cmd.sel_b) begin
        root_b <= cur;
      end else begin
        root_a <= cur;
      end
    end
    if (cmd.rank_cap) begin
      rank_a <= r_rdata;
    end
    if (cmd.link) begin
      joined <= 1'b1;
    end
    if (cmd.publish) begin
      out_joined <= joined;
      out_total  <= sum;
      out_bad    <= bad;
      out_late   <= late;
      out_last   <= e_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kufm_ctrl.sv =====
// Controller state machine: sequences the two finds with path compression,
// the link, the result and the clearing pass. Depends on kufm_pkg.
`default_nettype none

module kufm_ctrl import kufm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  kufm_stat_t stat,
  output kufm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FIND_A,
    ST_COMP_A,
    ST_FIND_B,
    ST_COMP_B,
    ST_RANK_A,
    ST_LINK,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands for this cycle.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.bad) begin
          state_next = ST_DONE;
        end else begin
          cmd.start_walk = 1'b1;
          state_next     = ST_FIND_A;
        end
      end
      ST_FIND_A: begin
        if (stat.hit) begin
          cmd.save_root  = 1'b1;
          cmd.start_walk = 1'b1;
          state_next     = ST_COMP_A;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      ST_COMP_A: begin
        if (stat.at_root_a) begin
          cmd.sel_b      = 1'b1;
          cmd.start_walk = 1'b1;
          state_next     = ST_FIND_B;
        end else begin
          cmd.comp_step = 1'b1;
        end
      end
      ST_FIND_B: begin
        cmd.sel_b = 1'b1;
        if (stat.hit) begin
          cmd.save_root  = 1'b1;
          cmd.start_walk = 1'b1;
          state_next     = ST_COMP_B;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      ST_COMP_B: begin
        cmd.sel_b = 1'b1;
        if (stat.at_root_b) begin
          // The rank read of root a is issued here (rank_b low).
          state_next = stat.same_root ? ST_DONE : ST_RANK_A;
        end else begin
          cmd.comp_step = 1'b1;
        end
      end
      ST_RANK_A: begin
        cmd.rank_cap = 1'b1;
        cmd.rank_b   = 1'b1;
        state_next   = ST_LINK;
      end
      ST_LINK: begin
        cmd.link   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          if (stat.last) begin
            cmd.clear_sums = 1'b1;
            state_next     = ST_CLEAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for kruskal_union_find_mst_weight_unit: edges in, running spanning
// forest weight out, checked against an in-bench union-find predictor.
// Depends on kufm_pkg, the kufm_*_if interfaces and the unit itself.
module tb;
  import kufm_pkg::*;

  typedef struct {
    vertex_t from_v;
    vertex_t to_v;
    weight_t weight;
    logic    last;
  } edge_item_t;

  typedef struct {
    logic joined;
    sum_t total;
    logic bad;
    logic late;
    logic done;
  } mst_outcome_t;

  logic clk;
  logic rst;

  kufm_cfg_if    cfg_ch ();
  kufm_edge_if   edge_ch ();
  kufm_result_if result_ch ();

  kruskal_union_find_mst_weight_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .edges   (edge_ch),
    .results (result_ch)
  );

  // Predicted state of the disjoint-set forest and the running total.
  vertex_t forest_parent [MAX_VERTICES];
  rank_t   forest_rank [MAX_VERTICES];
  sum_t    forest_sum;
  weight_t last_weight;
  count_t  vertex_limit;

  edge_item_t   pending_edges[$];
  mst_outcome_t mst_outcomes[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned results_due;
  int unsigned edges_queued;
  int unsigned errors;
  int unsigned results_seen;
  int unsigned joins_seen;
  int unsigned bad_seen;
  int unsigned late_seen;
  int unsigned runs_closed;
  int unsigned cfg_writes;

  // Free-running clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every vertex becomes its own set again; the running sums clear.
  function automatic void clear_forest();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      forest_parent[v] = vertex_t'(v);
      forest_rank[v] = '0;
    end
    forest_sum = '0;
    last_weight = '0;
  endfunction

  // Root lookup with full path compression.
  function automatic vertex_t find_root(input vertex_t v);
    vertex_t r;
    vertex_t nxt;
    r = v;
    while (forest_parent[r] != r) r = forest_parent[r];
    while (v != r) begin
      nxt = forest_parent[v];
      forest_parent[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  // Applies one edge to the forest and returns the result the unit should give.
  function automatic mst_outcome_t apply_edge(input edge_item_t e);
    mst_outcome_t o;
    int unsigned  lim;
    vertex_t      ra;
    vertex_t      rb;
    logic [SUM_BITS:0] s;
    lim = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    o.bad = (e.from_v >= lim) || (e.to_v >= lim);
    o.late = e.weight < last_weight;
    o.joined = 1'b0;
    last_weight = e.weight;
    if (!o.bad) begin
      ra = find_root(e.from_v);
      rb = find_root(e.to_v);
      if (ra != rb) begin
        s = {1'b0, forest_sum} + e.weight;
        forest_sum = (s > SUM_MAX) ? SUM_MAX : s[SUM_BITS-1:0];
        o.joined = 1'b1;
        // Union by rank; the rank saturates.
        if (forest_rank[ra] < forest_rank[rb]) begin
          forest_parent[ra] = rb;
        end else begin
          forest_parent[rb] = ra;
          if (forest_rank[ra] == forest_rank[rb] && forest_rank[ra] < RANK_MAX)
            forest_rank[ra] = forest_rank[ra] + 1'b1;
        end
      end
    end
    o.total = forest_sum;
    o.done = e.last;
    if (e.last) clear_forest();
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Edge driver: presents queued edges and predicts each one as its beat is taken.
  always @(posedge clk) begin : edge_driver
    edge_item_t next_edge;
    if (rst) begin
      edge_ch.valid <= 1'b0;
    end else begin
      if (edge_ch.valid && edge_ch.ready) begin
        next_edge.from_v = edge_ch.edge_from;
        next_edge.to_v   = edge_ch.edge_to;
        next_edge.weight = edge_ch.edge_weight;
        next_edge.last   = edge_ch.last_edge;
        mst_outcomes.insert(mst_outcomes.size(), apply_edge(next_edge));
      end
      if (!edge_ch.valid || edge_ch.ready) begin
        if (pending_edges.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_edge = pending_edges.pop_front();
          edge_ch.edge_from   <= next_edge.from_v;
          edge_ch.edge_to     <= next_edge.to_v;
          edge_ch.edge_weight <= next_edge.weight;
          edge_ch.last_edge   <= next_edge.last;
          edge_ch.valid       <= 1'b1;
        end else begin
          edge_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and a field-by-field comparison.
  always @(posedge clk) begin : result_monitor
    mst_outcome_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (results_due != 0) results_due--;
        if (mst_outcomes.size() == 0) begin
          $error("result beat arrived with no edge outstanding");
          errors++;
        end else begin
          want = mst_outcomes.pop_front();
          check_field("edge_joined", 32'(want.joined), 32'(result_ch.edge_joined));
          check_field("run_total", 32'(want.total), 32'(result_ch.run_total));
          check_field("bad_vertex", 32'(want.bad), 32'(result_ch.bad_vertex));
          check_field("out_of_order", 32'(want.late), 32'(result_ch.out_of_order));
          check_field("run_done", 32'(want.done), 32'(result_ch.run_done));
          results_seen++;
          if (want.joined) joins_seen++;
          if (want.bad) bad_seen++;
          if (want.late) late_seen++;
          if (want.done) runs_closed++;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic push_edge(input int unsigned a, input int unsigned b, input int unsigned w,
                           input bit last);
    edge_item_t e;
    e.from_v = vertex_t'(a);
    e.to_v   = vertex_t'(b);
    e.weight = weight_t'(w);
    e.last   = last;
    pending_edges.insert(pending_edges.size(), e);
    results_due++;
    edges_queued++;
  endtask

  // Holds off until every queued edge has produced its result.
  task automatic drain();
    while (results_due != 0) @(posedge clk);
  endtask

  // Writes the vertex count; must be called at a rising edge with the unit idle.
  task automatic write_vert_count(input count_t value);
    cfg_ch.vert_count <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    vertex_limit = value;
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Queues one graph: mostly ascending weights over a small vertex window, with a few
  // out-of-range endpoints and weights that step backwards.
  task automatic queue_run(input int unsigned lim, input bit close);
    int unsigned n;
    int unsigned base;
    int unsigned m;
    int unsigned w;
    int unsigned a;
    int unsigned b;
    n = (lim < 2) ? lim : (($urandom_range(7) == 0) ? lim :
        $urandom_range(2, (lim < 24) ? lim : 24));
    base = (n == 0) ? 0 : $urandom_range(0, lim - n);
    m = $urandom_range(1, (n < 2) ? 6 : ((3 * n > 60) ? 60 : 3 * n));
    w = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 500);
    for (int unsigned k = 0; k < m; k++) begin
      if (n == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = base + $urandom_range(0, n - 1);
        b = base + $urandom_range(0, n - 1);
        // An occasional endpoint beyond the vertex count, where one exists.
        if (lim < MAX_VERTICES && $urandom_range(19) == 0) begin
          case ($urandom_range(2))
            0: a = $urandom_range(lim, 1023);
            1: b = $urandom_range(lim, 1023);
            default: begin
              a = $urandom_range(lim, 1023);
              b = $urandom_range(lim, 1023);
            end
          endcase
        end
      end
      if ($urandom_range(19) == 0) begin
        w = (w > 0) ? $urandom_range(0, w - 1) : 0;
      end else if ($urandom_range(2) != 0) begin
        w = w + $urandom_range(1, 300);
        if (w > 65535) w = 65535;
      end
      push_edge(a, b, w, close && (k == m - 1));
    end
  endtask

  // Stimulus: reset, a directed part, then random graphs under varying vertex counts.
  initial begin
    count_t      vc;
    int unsigned lim;
    int unsigned runs;
    int unsigned phase;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.vert_count = '0;
    edge_ch.valid = 1'b0;
    edge_ch.edge_from = '0;
    edge_ch.edge_to = '0;
    edge_ch.edge_weight = '0;
    edge_ch.last_edge = 1'b0;
    result_ch.ready = 1'b0;
    src_idle_pct = 35;
    sink_idle_pct = 35;
    results_due = 0;
    edges_queued = 0;
    errors = 0;
    results_seen = 0;
    joins_seen = 0;
    bad_seen = 0;
    late_seen = 0;
    runs_closed = 0;
    cfg_writes = 0;
    clear_forest();
    vertex_limit = VC_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset vertex count: joins, a self loop, a same-set edge, a weight going back,
    // the extreme vertices and weights, and a last edge that closes the run.
    push_edge(0, 1, 0, 1'b0);
    push_edge(1023, 1022, 5, 1'b0);
    push_edge(0, 0, 5, 1'b0);
    push_edge(1, 0, 5, 1'b0);
    push_edge(2, 3, 3, 1'b0);
    push_edge(1023, 0, 65535, 1'b0);
    push_edge(0, 1023, 65535, 1'b0);
    push_edge(682, 341, 100, 1'b1);
    drain();

    // Four vertices: endpoints beyond the count are ignored, also on the last edge.
    write_vert_count(count_t'(4));
    push_edge(4, 0, 10, 1'b0);
    push_edge(0, 4, 20, 1'b0);
    push_edge(3, 2, 20, 1'b0);
    push_edge(1023, 1023, 0, 1'b0);
    push_edge(0, 1, 1, 1'b0);
    push_edge(5, 5, 7, 1'b1);
    drain();

    // No vertices at all: every edge is bad.
    write_vert_count(count_t'(0));
    push_edge(0, 0, 1, 1'b0);
    push_edge(0, 0, 0, 1'b1);
    drain();

    // A count above the table size acts as the table size.
    write_vert_count(count_t'(2047));
    push_edge(1023, 512, 9, 1'b0);
    push_edge(512, 1023, 9, 1'b1);
    drain();

    // A single vertex: only the self loop is in range.
    write_vert_count(count_t'(1));
    push_edge(0, 0, 4, 1'b0);
    push_edge(1, 0, 4, 1'b1);
    drain();

    // Random phases; each begins idle with a new vertex count, and the last graph of a
    // phase is sometimes left open so the count changes mid run.
    edges_queued = 0;
    phase = 0;
    while (edges_queued < 1000) begin
      drain();
      if (phase == 4) begin
        vc = VC_RESET;
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = 35;
        sink_idle_pct = 35;
        case ($urandom_range(11))
          0: vc = count_t'(0);
          1: vc = count_t'(1);
          2: vc = count_t'(2);
          3: vc = count_t'(2047);
          4, 5: vc = VC_RESET;
          default: vc = count_t'($urandom_range(3, 1023));
        endcase
      end
      write_vert_count(vc);
      lim = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
      if (phase == 4) begin
        // A long stretch with no idling on either side.
        while (results_due < 150) queue_run(lim, 1'b1);
      end else begin
        runs = $urandom_range(1, 4);
        for (int unsigned r = 0; r < runs; r++)
          queue_run(lim, (r < runs - 1) || ($urandom_range(3) != 0));
      end
      phase++;
    end

    drain();
    repeat (64) @(posedge clk);
    if (mst_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", mst_outcomes.size());
      errors++;
    end
    $display("Checked %0d results: %0d edges taken, %0d with bad endpoints, %0d out of order.",
             results_seen, joins_seen, bad_seen, late_seen);
    $display("Closed %0d graphs over %0d vertex count settings, from none up to 2047.",
             runs_closed, cfg_writes);
    if (errors == 0) begin
      $display("** kruskal_union_find_mst_weight_unit: PASSED **");
    end else begin
      $display("** kruskal_union_find_mst_weight_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #100000000;
    $display("** kruskal_union_find_mst_weight_unit: FAILED **");
    $finish;
  end

endmodule
